// ===== sv/sparse_polynomial_add_top_macros.svh =====
// ----------------------------------------------------------------------------
// sparse polynomial adder assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_ADD_TOP_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADD_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPA_ASSERT_NOW(lbl, ante, cons, msg)
`define SPA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/spa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// shared types and constants of the sparse polynomial adder
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int COEF_W       = 16;
    localparam int EXP_W        = 16;
    localparam int SUM_W        = COEF_W + 1;
    localparam int RESULT_LIMIT = 32;
    localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

    // one stored term, exponent in the upper half
    typedef struct packed {
        logic [EXP_W-1:0]         expo;
        logic signed [COEF_W-1:0] coef;
    } t_term;

endpackage

// ===== sv/spa_term_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_term_mem
// term store of one polynomial, one write port, registered read port
// ----------------------------------------------------------------------------
module spa_term_mem
    import spa_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_term             i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_term             o_rdata
);

    t_term r_mem [0:DEPTH-1];
    t_term r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sparse_polynomial_add_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_add_top
// adds two sparse polynomials by a sorted merge of their term lists
// ----------------------------------------------------------------------------
// Terms of both polynomials arrive on the slave stream, one per transfer,
// tuser[0] picking the list (0 first, 1 second) and tuser[1] set for a real
// term; a transfer with tuser[1] low closes its list, as does tlast. Terms
// beyond MAX_TERMS are dropped and transfers for an already closed list are
// ignored. Once both lists are closed the block merges them in ascending
// exponent order, adds coefficients of equal exponents, drops zero sums and
// streams the result terms (at most 32, last one with tlast) on the master
// stream; if nothing survives a single marker with tuser[0] set and tlast
// set is sent. Each merge step reads the term memories, whose read port is
// registered, in S_RD and then compares the exponents in S_CMP, which waits
// while the master stream is stalled; closing a run passes through S_FIN.
// The slave side is not ready during the merge.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_top
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input terms
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] coefficient, [31:16] exponent
    input  logic [1:0]  i_s_tuser,   // [0] list_select, [1] term_valid
    input  logic        i_s_tlast,   // last_term
    // result terms
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [16:0] sum_coefficient, [32:17] sum_exponent, zero pad
    output logic [0:0]  o_m_tuser,   // [0] result_empty
    output logic        o_m_tlast    // last_result
);

`include "sparse_polynomial_add_top_macros.svh"

    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    // sequencer states
    localparam logic [1:0] S_LOAD = 2'd0;   // taking terms
    localparam logic [1:0] S_RD   = 2'd1;   // memory read in flight
    localparam logic [1:0] S_CMP  = 2'd2;   // compare heads, one merge step
    localparam logic [1:0] S_FIN  = 2'd3;   // flush last term or empty marker

    // control registers
    logic [1:0]           r_state,   n_state;
    logic [CNT_W-1:0]     r_cnt_a,   n_cnt_a;
    logic [CNT_W-1:0]     r_cnt_b,   n_cnt_b;
    logic                 r_done_a,  n_done_a;
    logic                 r_done_b,  n_done_b;
    logic [CNT_W-1:0]     r_ptr_a,   n_ptr_a;
    logic [CNT_W-1:0]     r_ptr_b,   n_ptr_b;
    logic [RES_CNT_W-1:0] r_res_cnt, n_res_cnt;
    logic                 r_hold_vld, n_hold_vld;
    logic                 r_out_vld, n_out_vld;

    // payload registers
    logic signed [SUM_W-1:0] r_hold_coef, n_hold_coef;
    logic [EXP_W-1:0]        r_hold_exp,  n_hold_exp;
    logic signed [SUM_W-1:0] r_out_coef,  n_out_coef;
    logic [EXP_W-1:0]        r_out_exp,   n_out_exp;
    logic                    r_out_empty, n_out_empty;
    logic                    r_out_last,  n_out_last;

    // load side
    logic             in_xfer, sel, term_vld, sel_done, wr_en, close_list;
    logic [CNT_W-1:0] sel_cnt;
    t_term            wr_term;

    // merge side
    t_term                   rd_a, rd_b;
    logic                    a_left, b_left, take_a, take_b, cand_nz, out_free;
    logic signed [SUM_W-1:0] cand_coef;
    logic [EXP_W-1:0]        cand_exp;

    assign in_xfer  = i_s_tvalid && o_s_tready;
    assign sel      = i_s_tuser[0];
    assign term_vld = i_s_tuser[1];
    assign sel_done = sel ? r_done_b : r_done_a;
    assign sel_cnt  = sel ? r_cnt_b : r_cnt_a;
    assign wr_en    = in_xfer && !sel_done && term_vld && (sel_cnt < CNT_W'(MAX_TERMS));
    assign close_list = in_xfer && !sel_done && (!term_vld || i_s_tlast);
    assign wr_term.coef = i_s_tdata[15:0];
    assign wr_term.expo = i_s_tdata[31:16];

    spa_term_mem #(
        .DEPTH  (MAX_TERMS),
        .ADDR_W (ADDR_W)
    ) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (wr_en && !sel),
        .i_waddr (r_cnt_a[ADDR_W-1:0]),
        .i_wdata (wr_term),
        .i_raddr (r_ptr_a[ADDR_W-1:0]),
        .o_rdata (rd_a)
    );

    spa_term_mem #(
        .DEPTH  (MAX_TERMS),
        .ADDR_W (ADDR_W)
    ) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (wr_en && sel),
        .i_waddr (r_cnt_b[ADDR_W-1:0]),
        .i_wdata (wr_term),
        .i_raddr (r_ptr_b[ADDR_W-1:0]),
        .o_rdata (rd_b)
    );

    // head compare, equal exponents take both heads
    assign a_left = r_ptr_a < r_cnt_a;
    assign b_left = r_ptr_b < r_cnt_b;
    assign take_a = a_left && (!b_left || (rd_a.expo <= rd_b.expo));
    assign take_b = b_left && (!a_left || (rd_b.expo <= rd_a.expo));
    assign cand_coef = (take_a ? SUM_W'(rd_a.coef) : SUM_W'(0))
                     + (take_b ? SUM_W'(rd_b.coef) : SUM_W'(0));
    assign cand_exp = take_a ? rd_a.expo : rd_b.expo;
    assign cand_nz  = cand_coef != SUM_W'(0);
    assign out_free = !r_out_vld || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_done_a    = r_done_a;
        n_done_b    = r_done_b;
        n_ptr_a     = r_ptr_a;
        n_ptr_b     = r_ptr_b;
        n_res_cnt   = r_res_cnt;
        n_hold_vld  = r_hold_vld;
        n_hold_coef = r_hold_coef;
        n_hold_exp  = r_hold_exp;
        n_out_vld   = r_out_vld && !i_m_tready;
        n_out_coef  = r_out_coef;
        n_out_exp   = r_out_exp;
        n_out_empty = r_out_empty;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_LOAD: begin
                if (wr_en && !sel) begin
                    n_cnt_a = r_cnt_a + 1'b1;
                end
                if (wr_en && sel) begin
                    n_cnt_b = r_cnt_b + 1'b1;
                end
                if (close_list && !sel) begin
                    n_done_a = 1'b1;
                end
                if (close_list && sel) begin
                    n_done_b = 1'b1;
                end
                if (n_done_a && n_done_b) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = (a_left || b_left) ? S_CMP : S_FIN;
            end
            S_CMP: begin
                if (out_free) begin
                    n_ptr_a = r_ptr_a + CNT_W'(take_a);
                    n_ptr_b = r_ptr_b + CNT_W'(take_b);
                    n_state = S_RD;
                    if (cand_nz) begin
                        // previous held term is now known not to be the last
                        if (r_hold_vld) begin
                            n_out_vld   = 1'b1;
                            n_out_coef  = r_hold_coef;
                            n_out_exp   = r_hold_exp;
                            n_out_empty = 1'b0;
                            n_out_last  = 1'b0;
                        end
                        n_hold_vld  = 1'b1;
                        n_hold_coef = cand_coef;
                        n_hold_exp  = cand_exp;
                        n_res_cnt   = r_res_cnt + 1'b1;
                        if (r_res_cnt + 1'b1 == RES_CNT_W'(RESULT_LIMIT)) begin
                            n_state = S_FIN;
                        end
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_coef  = r_hold_vld ? r_hold_coef : SUM_W'(0);
                    n_out_exp   = r_hold_vld ? r_hold_exp : EXP_W'(0);
                    n_out_empty = !r_hold_vld;
                    n_out_last  = 1'b1;
                    n_cnt_a     = '0;
                    n_cnt_b     = '0;
                    n_done_a    = 1'b0;
                    n_done_b    = 1'b0;
                    n_ptr_a     = '0;
                    n_ptr_b     = '0;
                    n_res_cnt   = '0;
                    n_hold_vld  = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_done_a   <= 1'b0;
            r_done_b   <= 1'b0;
            r_ptr_a    <= '0;
            r_ptr_b    <= '0;
            r_res_cnt  <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_done_a   <= n_done_a;
            r_done_b   <= n_done_b;
            r_ptr_a    <= n_ptr_a;
            r_ptr_b    <= n_ptr_b;
            r_res_cnt  <= n_res_cnt;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_coef <= n_hold_coef;
        r_hold_exp  <= n_hold_exp;
        r_out_coef  <= n_out_coef;
        r_out_exp   <= n_out_exp;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    assign o_s_tready = r_state == S_LOAD;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'b0, r_out_exp, r_out_coef};
    assign o_m_tuser  = r_out_empty;
    assign o_m_tlast  = r_out_last;

    // checks
    `SPA_ASSERT_NOW(a_res_limit, 1'b1, r_res_cnt <= RES_CNT_W'(RESULT_LIMIT),
        "result count above limit")
    `SPA_ASSERT_NOW(a_ptr_range, 1'b1, (r_ptr_a <= r_cnt_a) && (r_ptr_b <= r_cnt_b),
        "merge pointer beyond stored terms")
    `SPA_ASSERT_NOW(a_nonzero, o_m_tvalid && !o_m_tuser[0], r_out_coef != SUM_W'(0),
        "zero coefficient term sent")
    `SPA_ASSERT_NOW(a_empty_last, o_m_tvalid && o_m_tuser[0], o_m_tlast,
        "empty marker without last")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sparse polynomial adder
// ----------------------------------------------------------------------------
// Term lists for pairs of polynomials are sent on the slave stream. A
// scoreboard keeps its own copy of both term lists. When a pair closes, it
// merges the lists into the expected sum terms. Every result transfer on the
// master stream is checked against the oldest expected term.
//
// A short directed part comes first: empty lists, extreme coefficients and
// exponents, full cancellation, zero coefficients, lists closed by a
// not-valid transfer, transfers for an already closed list, and unsorted
// input. Random pairs follow. These have random sizes, including overlong
// lists and full 16 + 16 pairs. Both stream sides use random gaps.
// ----------------------------------------------------------------------------
module testbench;
    import spa_pkg::*;

    localparam int TERM_CAP = 16;

    // one result term as it should appear on the master stream
    typedef struct packed {
        logic signed [SUM_W-1:0] coef;
        logic [EXP_W-1:0]        expo;
        logic                    empty;
        logic                    last;
    } t_sum_term;

    // predicts the sum of each pair of term lists and checks the results
    class poly_sum_board;
        logic signed [COEF_W-1:0] coef_mem [2][TERM_CAP];
        logic [EXP_W-1:0]         exp_mem  [2][TERM_CAP];
        int                       term_cnt [2];
        bit                       closed   [2];
        t_sum_term                sums_due [$];
        int                       n_errors;
        int                       n_checked;
        int                       n_pairs;
        int                       n_cancelled;

        function new();
            term_cnt    = '{0, 0};
            closed      = '{0, 0};
            n_errors    = 0;
            n_checked   = 0;
            n_pairs     = 0;
            n_cancelled = 0;
        endfunction

        function int pending();
            return sums_due.size();
        endfunction

        // sorted merge of both lists, zero sums dropped, run capped
        function void merge_lists();
            t_sum_term               run [$];
            t_sum_term               r;
            logic signed [SUM_W-1:0] s;
            logic [EXP_W-1:0]        e;
            int                      a;
            int                      b;
            int                      k;
            a = 0;
            b = 0;
            while (a < term_cnt[0] || b < term_cnt[1]) begin
                if (a < term_cnt[0] && b < term_cnt[1] && exp_mem[0][a] == exp_mem[1][b]) begin
                    s = SUM_W'(coef_mem[0][a]);
                    s = s + SUM_W'(coef_mem[1][b]);
                    e = exp_mem[0][a];
                    a++;
                    b++;
                end else if (a < term_cnt[0] &&
                             (b >= term_cnt[1] || exp_mem[0][a] < exp_mem[1][b])) begin
                    s = SUM_W'(coef_mem[0][a]);
                    e = exp_mem[0][a];
                    a++;
                end else begin
                    s = SUM_W'(coef_mem[1][b]);
                    e = exp_mem[1][b];
                    b++;
                end
                if (s != 0 && run.size() < RESULT_LIMIT) begin
                    r = '{coef: s, expo: e, empty: 1'b0, last: 1'b0};
                    run.push_back(r);
                end
            end
            n_pairs++;
            // nothing survived: a lone empty marker closes the run
            if (run.size() == 0) begin
                n_cancelled++;
                r = '{coef: '0, expo: '0, empty: 1'b1, last: 1'b1};
                sums_due.push_back(r);
            end else begin
                for (k = 0; k < run.size(); k++) begin
                    r = run[k];
                    r.last = (k == run.size() - 1);
                    sums_due.push_back(r);
                end
            end
        endfunction

        // one accepted input transfer
        function void note_term(bit sel, bit valid, logic signed [COEF_W-1:0] coef,
                                logic [EXP_W-1:0] expo, bit last);
            if (closed[sel])
                return;
            if (valid && term_cnt[sel] < TERM_CAP) begin
                coef_mem[sel][term_cnt[sel]] = coef;
                exp_mem[sel][term_cnt[sel]]  = expo;
                term_cnt[sel]++;
            end
            if (!valid || last)
                closed[sel] = 1'b1;
            if (closed[0] && closed[1]) begin
                merge_lists();
                term_cnt = '{0, 0};
                closed   = '{0, 0};
            end
        endfunction

        // one accepted result transfer
        function void check_sum(logic signed [SUM_W-1:0] coef, logic [EXP_W-1:0] expo,
                                bit empty, bit last);
            t_sum_term want;
            if (sums_due.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected result, got coef %0d exp %0d empty %0b last %0b",
                         $time, coef, expo, empty, last);
                return;
            end
            want = sums_due.pop_front();
            n_checked++;
            if (want.coef !== coef || want.expo !== expo || want.empty !== empty ||
                want.last !== last) begin
                n_errors++;
                $display("%0t ns: result mismatch, expected coef %0d exp %0d empty %0b last %0b",
                         $time, want.coef, want.expo, want.empty, want.last);
                $display("%0t ns:                  got coef %0d exp %0d empty %0b last %0b",
                         $time, coef, expo, empty, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [15:0] coefficient, [31:16] exponent
    logic [1:0]  s_tuser  = '0;    // [0] list_select, [1] term_valid
    logic        s_tlast  = 1'b0;  // last_term
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [16:0] sum_coefficient, [32:17] sum_exponent
    logic [0:0]  m_tuser;          // [0] result_empty
    logic        m_tlast;          // last_result

    poly_sum_board board = new();

    // planned term lists of the next pair, up to 19 terms to overflow the store
    logic signed [COEF_W-1:0] pc [2][20];
    logic [EXP_W-1:0]         pe [2][20];
    int                       pn [2];

    bit no_idle     = 1'b0;  // set for stretches that run without gaps
    int hold_cycles = 0;
    int n_fed       = 0;
    int n_ignored   = 0;
    int pair_no;

    sparse_polynomial_add_top #(
        .MAX_TERMS (TERM_CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, some long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // list length: mostly short, some full, a few past the store size
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 6);
        else if (r < 18)
            return $urandom_range(7, 16);
        else
            return $urandom_range(17, 19);
    endfunction

    function automatic bit seen(int q[$], int v);
        foreach (q[k])
            if (q[k] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    // receiver: random stalls of tready, changed at the falling edge
    always @(negedge i_clk) begin
        if (hold_cycles == 0 && !no_idle && $urandom_range(0, 3) == 0)
            hold_cycles = pick_gap();
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // every result transfer goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            board.check_sum($signed(m_tdata[16:0]), m_tdata[32:17], m_tuser[0], m_tlast);
    end

    // one slave transfer, entered and left at a falling edge
    task automatic feed_term(bit sel, bit valid, logic signed [COEF_W-1:0] coef,
                             logic [EXP_W-1:0] expo, bit last, bit ignored);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {expo, coef};
        s_tuser  <= {valid, sel};
        s_tlast  <= last;
        forever begin
            @(posedge i_clk);
            if (s_tready)
                break;
        end
        board.note_term(sel, valid, coef, expo, last);
        if (ignored)
            n_ignored++;
        else
            n_fed++;
        @(negedge i_clk);
    endtask

    // hold the sender until every expected result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // plan a pair: unique exponents, some shared between lists and some cancelling
    task automatic build_pair(int n0, int n1, int share_pct);
        int vals [$];
        int v;
        int k;
        int j;
        bit wide;
        int base;
        wide = 1'($urandom_range(0, 1));
        base = $urandom_range(0, 65535 - 64);
        while (vals.size() < n0) begin
            v = wide ? $urandom_range(0, 65535) : base + $urandom_range(0, 63);
            if (!seen(vals, v))
                vals.push_back(v);
        end
        vals.sort();
        if ($urandom_range(0, 9) == 0)
            vals.shuffle();
        for (k = 0; k < n0; k++) begin
            pe[0][k] = EXP_W'(vals[k]);
            pc[0][k] = ($urandom_range(0, 19) == 0) ? '0 : COEF_W'($urandom);
        end
        vals.delete();
        while (vals.size() < n1) begin
            if (n0 > 0 && $urandom_range(0, 99) < share_pct)
                v = int'(pe[0][$urandom_range(0, n0 - 1)]);
            else
                v = wide ? $urandom_range(0, 65535) : base + $urandom_range(0, 63);
            if (!seen(vals, v))
                vals.push_back(v);
        end
        vals.sort();
        if ($urandom_range(0, 9) == 0)
            vals.shuffle();
        for (k = 0; k < n1; k++) begin
            pe[1][k] = EXP_W'(vals[k]);
            pc[1][k] = ($urandom_range(0, 19) == 0) ? '0 : COEF_W'($urandom);
            for (j = 0; j < n0; j++)
                if (pe[0][j] == pe[1][k] && $urandom_range(0, 1))
                    pc[1][k] = -pc[0][j];
        end
        pn[0] = n0;
        pn[1] = n1;
    endtask

    // send the planned pair, both lists interleaved at random
    task automatic send_pair();
        int nxt [2];
        bit fin [2];
        bit by_void [2];
        int s;
        bit last;
        nxt = '{0, 0};
        fin = '{0, 0};
        for (s = 0; s < 2; s++)
            by_void[s] = (pn[s] == 0) || ($urandom_range(0, 4) == 0);
        while (!(fin[0] && fin[1])) begin
            // stray transfer for the list that is already closed
            if (fin[0] != fin[1] && $urandom_range(0, 6) == 0) begin
                feed_term(fin[1], 1'($urandom), COEF_W'($urandom), EXP_W'($urandom),
                          1'($urandom), 1'b1);
                continue;
            end
            s = fin[0] ? 1 : fin[1] ? 0 : $urandom_range(0, 1);
            if (nxt[s] < pn[s]) begin
                last = !by_void[s] && nxt[s] == pn[s] - 1;
                feed_term(1'(s), 1'b1, pc[s][nxt[s]], pe[s][nxt[s]], last, 1'b0);
                nxt[s]++;
                fin[s] = last;
            end else begin
                // not-valid transfer closes the list
                feed_term(1'(s), 1'b0, COEF_W'($urandom), EXP_W'($urandom),
                          1'($urandom), 1'b0);
                fin[s] = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // both lists empty: lone empty marker
        feed_term(1'b0, 1'b0, 16'sh1234, 16'hffff, 1'b0, 1'b0);
        feed_term(1'b1, 1'b0, 16'sh8000, 16'h0001, 1'b1, 1'b0);
        // largest positive sum at the top exponent
        feed_term(1'b0, 1'b1, 16'sh7fff, 16'hffff, 1'b1, 1'b0);
        feed_term(1'b1, 1'b1, 16'sh7fff, 16'hffff, 1'b1, 1'b0);
        // most negative sum at exponent zero, second list first
        feed_term(1'b1, 1'b1, 16'sh8000, 16'h0000, 1'b1, 1'b0);
        feed_term(1'b0, 1'b1, 16'sh8000, 16'h0000, 1'b1, 1'b0);
        // full cancellation
        feed_term(1'b0, 1'b1, 16'sd5, 16'd7, 1'b1, 1'b0);
        feed_term(1'b1, 1'b1, -16'sd5, 16'd7, 1'b1, 1'b0);
        // unmatched zero coefficient dropped, second list empty
        feed_term(1'b0, 1'b1, 16'sd0, 16'd3, 1'b0, 1'b0);
        feed_term(1'b0, 1'b1, 16'sd9, 16'd4, 1'b1, 1'b0);
        feed_term(1'b1, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0);
        // list closed by a not-valid transfer, then a stray term for it
        feed_term(1'b0, 1'b1, 16'sd1, 16'd1, 1'b0, 1'b0);
        feed_term(1'b0, 1'b0, 16'sd77, 16'd88, 1'b0, 1'b0);
        feed_term(1'b0, 1'b1, 16'sd100, 16'd200, 1'b1, 1'b1);
        feed_term(1'b1, 1'b1, 16'sd2, 16'd2, 1'b1, 1'b0);
        // unsorted first list
        feed_term(1'b0, 1'b1, 16'sd1, 16'd10, 1'b0, 1'b0);
        feed_term(1'b0, 1'b1, 16'sd2, 16'd5, 1'b1, 1'b0);
        feed_term(1'b1, 1'b1, 16'sd3, 16'd7, 1'b1, 1'b0);
        wait_drained();

        // random pairs, every eighth one full with distinct exponents
        pair_no = 0;
        while (n_fed < 250) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if (pair_no % 8 == 7)
                build_pair(TERM_CAP, TERM_CAP, 0);
            else
                build_pair(pick_len(), pick_len(), $urandom_range(0, 80));
            send_pair();
            if (pair_no % 6 == 5)
                wait_drained();
            pair_no++;
        end
        no_idle = 1'b0;

        wait_drained();
        // let any stray result show up
        repeat (100) @(negedge i_clk);
        $display("fed %0d terms and list closes plus %0d stray transfers over %0d pairs",
                 n_fed, n_ignored, board.n_pairs);
        $display("checked %0d result transfers, %0d of them empty markers",
                 board.n_checked, board.n_cancelled);
        if (board.n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin
        #5ms;
        $display("timeout: %0d results still expected", board.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sparse_polynomial_add_top.f =====
+incdir+sv
sv/spa_pkg.sv
sv/spa_term_mem.sv
sv/sparse_polynomial_add_top.sv
dv/testbench.sv
